// ===== design/tlt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlt_pkg
// Types, calendar constants and the month length table shared by the stamp
// successor pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tlt_pkg;

  typedef struct packed {
    logic [63:0] candidate_stamp;
    logic [63:0] reference_stamp;
  } tlt_item_t;

  typedef struct packed {
    logic [63:0] result_stamp;
    logic        took_candidate;
    logic        status;
  } tlt_result_t;

  // Calendar fields are zero based: month 0..11, day 0..30, minute 0..1439.
  typedef struct packed {
    logic [12:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [10:0] minute;
    logic        leap;
  } tlt_cal_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_DAY = 1'b1;

  localparam logic [31:0] YEAR_MIN    = 32'd535680;
  localparam logic [15:0] MON_MIN     = 16'd44640;
  localparam logic [10:0] DAY_MIN     = 11'd1440;
  localparam logic [10:0] LAST_MINUTE = 11'd1439;
  localparam logic [3:0]  LAST_MONTH  = 4'd11;
  localparam logic [6:0]  CENTURY     = 7'd100;

  // Exact reciprocals: each divisor has its power-of-two factor shifted out
  // first, and the rounding error stays below the bound for the input range.
  localparam logic [24:0] YEAR_RECIP    = 25'd32840850; // 1/4185, shift 37
  localparam logic [14:0] MON_RECIP     = 15'd24054;    // 1/1395, shift 25
  localparam logic [10:0] DAY_RECIP     = 11'd1457;     // 1/45,   shift 16
  localparam logic [11:0] CENTURY_RECIP = 12'd2622;     // 1/25,   shift 16

  localparam int UNPACK_LAT  = 6;
  localparam int ADVANCE_LAT = 2;

  function automatic logic [4:0] days_in_month(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== design/tlt_unpack.sv =====
// ----------------------------------------------------------------------------
// tlt_unpack
// Splits a minute count into year, month, day and minute with constant
// reciprocal multiplies, and flags Gregorian leap years. Six register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tlt_unpack (
  input  wire logic             clk,
  input  wire logic [31:0]      hi,
  output tlt_pkg::tlt_cal_t     cal
);
  import tlt_pkg::*;

  logic [49:0] s1_prod;
  logic [31:0] s1_hi;

  logic [12:0] s2_year;
  logic [19:0] s2_rem;

  logic [28:0] s3_mprod;
  logic [22:0] s3_cprod;
  logic [12:0] s3_year;
  logic [19:0] s3_rem;

  logic [3:0]  s4_month;
  logic [15:0] s4_rem;
  logic [12:0] s4_year;
  logic        s4_leap;

  logic [20:0] s5_dprod;
  logic [3:0]  s5_month;
  logic [15:0] s5_rem;
  logic [12:0] s5_year;
  logic        s5_leap;

  logic [12:0] year_q;
  logic [31:0] year_base;
  logic [3:0]  month_q;
  logic [31:0] month_base;
  logic [6:0]  cent_q;
  logic [12:0] cent_base;
  logic        div_by_100;
  logic        leap_year;
  logic [4:0]  day_q;
  logic [15:0] day_base;

  always_comb begin
    year_q     = s1_prod[49:37];
    year_base  = 32'(year_q) * YEAR_MIN;

    month_q    = s3_mprod[28:25];
    month_base = 32'(month_q) * 32'(MON_MIN);
    cent_q     = s3_cprod[22:16];
    cent_base  = 13'(cent_q) * 13'(CENTURY);
    div_by_100 = (s3_year == cent_base);
    // Year offset 1900 is a multiple of 4; a full year divisible by 400 has an
    // offset whose hundreds count is one more than a multiple of four.
    leap_year  = (s3_year[1:0] == 2'b00) && (!div_by_100 || (cent_q[1:0] == 2'b01));

    day_q      = s5_dprod[20:16];
    day_base   = 16'(day_q) * 16'(DAY_MIN);
  end

  always_ff @(posedge clk) begin
    s1_prod  <= 50'(hi[31:7]) * 50'(YEAR_RECIP);
    s1_hi    <= hi;

    s2_year  <= year_q;
    s2_rem   <= 20'(s1_hi - year_base);

    s3_mprod <= 29'(30'(s2_rem[19:5]) * 30'(MON_RECIP));
    s3_cprod <= 23'(s2_year[12:2]) * 23'(CENTURY_RECIP);
    s3_year  <= s2_year;
    s3_rem   <= s2_rem;

    s4_month <= month_q;
    s4_rem   <= 16'(32'(s3_rem) - month_base);
    s4_year  <= s3_year;
    s4_leap  <= leap_year;

    s5_dprod <= 21'(22'(s4_rem[15:5]) * 22'(DAY_RECIP));
    s5_month <= s4_month;
    s5_rem   <= s4_rem;
    s5_year  <= s4_year;
    s5_leap  <= s4_leap;

    cal.year   <= s5_year;
    cal.month  <= s5_month;
    cal.day    <= day_q;
    cal.minute <= 11'(s5_rem - day_base);
    cal.leap   <= s5_leap;
  end

endmodule

`default_nettype wire

// ===== design/tlt_advance.sv =====
// ----------------------------------------------------------------------------
// tlt_advance
// Checks the day against the true month length, steps the date by one minute
// with month and year rollover, and repacks it into a minute count.
// ----------------------------------------------------------------------------
`default_nettype none

module tlt_advance (
  input  wire logic              clk,
  input  wire tlt_pkg::tlt_cal_t cal,
  output logic [31:0]            packed_min,
  output logic                   bad_day
);
  import tlt_pkg::*;

  logic [12:0] a1_year;
  logic [3:0]  a1_month;
  logic [4:0]  a1_day;
  logic [10:0] a1_minute;
  logic        a1_bad;

  logic [4:0]  len;
  logic [12:0] year_next;
  logic [3:0]  month_next;
  logic [4:0]  day_next;
  logic [10:0] minute_next;
  logic [31:0] packed_next;

  always_comb begin
    len         = days_in_month(cal.leap, cal.month);
    year_next   = cal.year;
    month_next  = cal.month;
    day_next    = cal.day;
    minute_next = cal.minute + 11'd1;
    if (cal.minute >= LAST_MINUTE) begin
      minute_next = '0;
      if (cal.day == len - 5'd1) begin
        day_next = '0;
        if (cal.month == LAST_MONTH) begin
          month_next = '0;
          year_next  = cal.year + 13'd1;
        end else begin
          month_next = cal.month + 4'd1;
        end
      end else begin
        day_next = cal.day + 5'd1;
      end
    end
  end

  // The count wraps modulo 2^32 past the last representable year.
  always_comb begin
    packed_next = 32'(a1_year) * YEAR_MIN
                + 32'(a1_month) * 32'(MON_MIN)
                + 32'(a1_day) * 32'(DAY_MIN)
                + 32'(a1_minute);
  end

  always_ff @(posedge clk) begin
    a1_year    <= year_next;
    a1_month   <= month_next;
    a1_day     <= day_next;
    a1_minute  <= minute_next;
    a1_bad     <= (cal.day >= len);
    packed_min <= packed_next;
    bad_day    <= a1_bad;
  end

endmodule

`default_nettype wire

// ===== design/timestamp_later_than_top.sv =====
// ----------------------------------------------------------------------------
// timestamp_later_than_top
// Returns the candidate stamp if greater than the reference, else the smallest
// stamp above it, stepping the calendar on low-word wrap (bad day: zero, error).
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------
//  request   | start / busy          | item   (candidate_stamp, reference_stamp)
//  response  | done (one-cycle)      | result (result_stamp, took_candidate, status)
//
//  A transaction is taken at any edge with start high and busy low; one may
//  be taken every cycle. Its response appears on done after it has passed
//  the input register, the six-stage calendar unpack (three chained
//  reciprocal multiplies), the two-stage advance and repack, and the result
//  register. busy is high only during reset. The receiver cannot stall;
//  responses leave in request order.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_later_than_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire tlt_pkg::tlt_item_t  item,
  output logic                     done,
  output tlt_pkg::tlt_result_t     result
);
  import tlt_pkg::*;

  localparam int PIPE_LAT = UNPACK_LAT + ADVANCE_LAT;

  typedef struct packed {
    logic [63:0] stamp;
    logic        took;
    logic        advance;
  } tlt_side_t;

  tlt_item_t   in_q;
  logic        in_v;
  tlt_side_t   side;
  tlt_side_t   side_line [PIPE_LAT];
  logic        v_line    [PIPE_LAT];
  tlt_cal_t    cal;
  logic [31:0] packed_min;
  logic        bad_day;
  tlt_result_t result_next;
  logic        accept;
  logic        greater;

  assign busy   = rst;
  assign accept = start && !busy;

  always_comb begin
    greater      = in_q.candidate_stamp > in_q.reference_stamp;
    side.took    = greater;
    side.advance = !greater && (&in_q.reference_stamp[31:0]);
    side.stamp   = greater ? in_q.candidate_stamp
                 : {in_q.reference_stamp[63:32], in_q.reference_stamp[31:0] + 32'd1};
  end

  tlt_unpack u_unpack (
    .clk (clk),
    .hi  (in_q.reference_stamp[63:32]),
    .cal (cal)
  );

  tlt_advance u_advance (
    .clk        (clk),
    .cal        (cal),
    .packed_min (packed_min),
    .bad_day    (bad_day)
  );

  always_comb begin
    result_next.result_stamp   = side_line[PIPE_LAT-1].stamp;
    result_next.took_candidate = side_line[PIPE_LAT-1].took;
    result_next.status         = STATUS_OK;
    if (side_line[PIPE_LAT-1].advance) begin
      if (bad_day) begin
        result_next.result_stamp = '0;
        result_next.status       = STATUS_BAD_DAY;
      end else begin
        result_next.result_stamp = {packed_min, 32'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
      done <= 1'b0;
      for (int i = 0; i < PIPE_LAT; i++) begin
        v_line[i] <= 1'b0;
      end
    end else begin
      in_v      <= accept;
      v_line[0] <= in_v;
      for (int i = 1; i < PIPE_LAT; i++) begin
        v_line[i] <= v_line[i-1];
      end
      done <= v_line[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= item;
    end
    side_line[0] <= side;
    for (int i = 1; i < PIPE_LAT; i++) begin
      side_line[i] <= side_line[i-1];
    end
    result <= result_next;
  end

  // Every accepted transaction produces its response on done after the full pipeline.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(PIPE_LAT + 2) done)
    else $error("response missing after accepted transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, PIPE_LAT + 2))
    else $error("response without a matching transaction");

  a_cal_range: assert property (@(posedge clk) disable iff (rst)
    v_line[UNPACK_LAT-1] |->
      (cal.month <= LAST_MONTH) && (cal.day < 5'd31) && (cal.minute <= LAST_MINUTE))
    else $error("unpacked calendar field out of range");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == STATUS_BAD_DAY)) |->
      (!result.took_candidate && (result.result_stamp == 64'd0)))
    else $error("bad day response carries a stamp");

endmodule

`default_nettype wire

// ===== dv/tb_timestamp_later_than_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timestamp_later_than_top
// Self-checking bench for the stamp successor. Each accepted request is run
// through a calendar predictor and the expected response is queued. Every
// done strobe is checked against the oldest queued response. Directed tests
// cover the compare boundary, the fraction step, calendar rollover, invalid
// days and minute overflow. They are followed by bursty random traffic, half
// of it stamps built from calendar fields, some of which hold invalid days.
// ----------------------------------------------------------------------------

module tb_timestamp_later_than_top;
  import tlt_pkg::*;

  localparam int          RESET_CYCLES   = 12;
  localparam int          RESULT_LATENCY = 10;
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          RANDOM_ITEMS   = 900;
  localparam int unsigned EPOCH_YEAR     = 1900;
  localparam int unsigned MINS_PER_DAY   = 1440;
  localparam int unsigned MINS_PER_MONTH = 31 * 1440;
  localparam int unsigned MINS_PER_YEAR  = 12 * 31 * 1440;
  localparam int unsigned FINAL_MINUTE   = 1439;
  localparam int unsigned DECEMBER       = 11;
  localparam int unsigned FEBRUARY       = 1;
  localparam int unsigned APRIL          = 3;
  localparam int unsigned JUNE           = 5;
  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  tlt_item_t   item;
  logic        done;
  tlt_result_t result;

  tlt_result_t expected_results [$];
  tlt_result_t oldest_expected;
  int          mismatch_count;
  int          quiet_cycles;

  timestamp_later_than_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  // Month and day are zero based here, as in the stamp encoding.
  function automatic logic [31:0] cal_minutes(input int unsigned year, input int unsigned month,
                                              input int unsigned day, input int unsigned minute);
    longint unsigned total;
    total = (((longint'(year - EPOCH_YEAR) * 12 + month) * 31 + day) * MINS_PER_DAY) + minute;
    return total[31:0];
  endfunction

  function automatic tlt_item_t make_request(input logic [63:0] cand, input logic [63:0] refs);
    tlt_item_t it;
    it.candidate_stamp = cand;
    it.reference_stamp = refs;
    return it;
  endfunction

  function automatic tlt_result_t predict_successor(input tlt_item_t it);
    tlt_result_t     r;
    logic [31:0]     hi;
    logic [31:0]     lo;
    int unsigned     yr;
    int unsigned     mon;
    int unsigned     dy;
    int unsigned     mn;
    int unsigned     len;
    logic            leap;
    longint unsigned repacked;
    r = '0;
    r.status = STATUS_OK;
    hi = it.reference_stamp[63:32];
    lo = it.reference_stamp[31:0];
    if (it.candidate_stamp > it.reference_stamp) begin
      r.result_stamp   = it.candidate_stamp;
      r.took_candidate = 1'b1;
      return r;
    end
    if (lo != 32'hFFFF_FFFF) begin
      r.result_stamp = {hi, lo + 32'd1};
      return r;
    end
    yr   = hi / MINS_PER_YEAR + EPOCH_YEAR;
    mon  = (hi % MINS_PER_YEAR) / MINS_PER_MONTH;
    dy   = (hi % MINS_PER_MONTH) / MINS_PER_DAY;
    mn   = hi % MINS_PER_DAY;
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    len  = MONTH_DAYS[mon] + ((mon == FEBRUARY && leap) ? 1 : 0);
    if (dy + 1 > len) begin
      r.status = STATUS_BAD_DAY;
      return r;
    end
    if (mn >= FINAL_MINUTE) begin
      mn = 0;
      if (dy + 1 == len) begin
        dy = 0;
        if (mon == DECEMBER) begin
          mon = 0;
          yr  = yr + 1;
        end else begin
          mon = mon + 1;
        end
      end else begin
        dy = dy + 1;
      end
    end else begin
      mn = mn + 1;
    end
    // The repacked minute count wraps modulo 2^32 past the last year.
    repacked = (((longint'(yr - EPOCH_YEAR) * 12 + mon) * 31 + dy) * MINS_PER_DAY) + mn;
    r.result_stamp = {repacked[31:0], 32'd0};
    return r;
  endfunction

  // Start stays high between back-to-back requests, so a burst has no gaps.
  task automatic send_request(input tlt_item_t it);
    @(negedge clk);
    start = 1'b1;
    item  = it;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_successor(it));
  endtask

  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  task automatic wait_all_results();
    idle_sender(1);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_candidate_compare();
    logic [63:0] stamp;
    stamp = {$urandom, $urandom};
    send_request(make_request(64'h0123_4567_89AB_CDF0, 64'h0123_4567_89AB_CDEF));
    send_request(make_request('1, 64'd0));
    send_request(make_request(stamp, stamp));
    send_request(make_request(64'd0, 64'd0));
    send_request(make_request(64'h0000_0001_0000_0000, 64'h0000_0001_0000_0001));
    wait_all_results();
  endtask

  task automatic test_fraction_step();
    send_request(make_request(64'd0, {cal_minutes(2024, 6, 14, 600), $urandom & 32'h7FFF_FFFF}));
    send_request(make_request(64'd0, 64'h0000_0010_FFFF_FFFE));
    send_request(make_request(64'd0, 64'hFFFF_FFFF_0000_0000));
    wait_all_results();
  endtask

  task automatic test_calendar_rollover();
    send_request(make_request(64'd0, {cal_minutes(1999, 5, 9, 0), 32'hFFFF_FFFF}));
    send_request(make_request(64'd0, {cal_minutes(1999, 5, 9, FINAL_MINUTE), 32'hFFFF_FFFF}));
    send_request(make_request(64'd0, {cal_minutes(2010, 0, 30, FINAL_MINUTE), 32'hFFFF_FFFF}));
    send_request(make_request(64'd0, {cal_minutes(1999, DECEMBER, 30, FINAL_MINUTE),
                                      32'hFFFF_FFFF}));
    send_request(make_request(64'd0, {cal_minutes(1901, FEBRUARY, 27, FINAL_MINUTE),
                                      32'hFFFF_FFFF}));
    send_request(make_request(64'd0, {cal_minutes(2000, FEBRUARY, 27, FINAL_MINUTE),
                                      32'hFFFF_FFFF}));
    send_request(make_request(64'd0, {cal_minutes(2000, FEBRUARY, 28, FINAL_MINUTE),
                                      32'hFFFF_FFFF}));
    send_request(make_request(64'd0, {cal_minutes(1900, FEBRUARY, 27, FINAL_MINUTE),
                                      32'hFFFF_FFFF}));
    send_request(make_request(64'd0, {cal_minutes(2021, APRIL, 29, FINAL_MINUTE),
                                      32'hFFFF_FFFF}));
    wait_all_results();
  endtask

  // Days past the true month length give an error status and a zero stamp.
  task automatic test_bad_day();
    send_request(make_request(64'd0, {cal_minutes(1900, FEBRUARY, 28, 0), 32'hFFFF_FFFF}));
    send_request(make_request(64'd0, {cal_minutes(2004, FEBRUARY, 29, 77), 32'hFFFF_FFFF}));
    send_request(make_request(64'd0, {cal_minutes(2004, APRIL, 30, FINAL_MINUTE),
                                      32'hFFFF_FFFF}));
    send_request(make_request(64'd0, {cal_minutes(2023, FEBRUARY, 28, 1000), 32'hFFFF_FFFF}));
    send_request(make_request(64'd0, {cal_minutes(9000, JUNE, 30, 5), 32'hFFFF_FFFF}));
    wait_all_results();
  endtask

  // The largest minute count sits mid-October, so one more minute wraps to zero.
  task automatic test_minute_overflow();
    send_request(make_request(64'd0, '1));
    send_request(make_request('1, '1));
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    int          burst_left;
    int unsigned yr;
    int unsigned mon;
    int unsigned dy;
    int unsigned mn;
    logic [63:0] cand_v;
    logic [63:0] ref_v;
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 10);
      end
      if (n == RANDOM_ITEMS / 2) wait_all_results();
      case ($urandom_range(0, 9))
        0, 1: begin
          ref_v = {$urandom, $urandom};
        end
        2, 3: begin
          ref_v = {$urandom, $urandom & 32'hFFFF_FFFE};
        end
        9: begin
          ref_v = {($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 3000),
                   32'hFFFF_FFFF};
        end
        default: begin
          yr  = ($urandom_range(0, 2) == 0) ? EPOCH_YEAR + 4 * $urandom_range(0, 2004)
                                            : EPOCH_YEAR + $urandom_range(0, 8016);
          mon = ($urandom_range(0, 3) == 0) ? FEBRUARY : $urandom_range(0, 11);
          dy  = ($urandom_range(0, 1) == 0) ? $urandom_range(26, 30) : $urandom_range(0, 30);
          mn  = ($urandom_range(0, 1) == 0) ? FINAL_MINUTE : $urandom_range(0, FINAL_MINUTE);
          ref_v = {cal_minutes(yr, mon, dy, mn), 32'hFFFF_FFFF};
        end
      endcase
      case ($urandom_range(0, 3))
        0:       cand_v = ref_v;
        1:       cand_v = ref_v & {$urandom, $urandom};
        2:       cand_v = ref_v + 64'd1;
        default: cand_v = {$urandom, $urandom};
      endcase
      send_request(make_request(cand_v, ref_v));
      burst_left--;
    end
    wait_all_results();
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction: actual stamp %h took %b status %b",
                 $time, result.result_stamp, result.took_candidate, result.status);
        mismatch_count++;
      end else begin
        oldest_expected = expected_results.pop_front();
        if (result.result_stamp !== oldest_expected.result_stamp) begin
          $display("%0t: result_stamp expected %h actual %h",
                   $time, oldest_expected.result_stamp, result.result_stamp);
          mismatch_count++;
        end
        if (result.took_candidate !== oldest_expected.took_candidate) begin
          $display("%0t: took_candidate expected %b actual %b",
                   $time, oldest_expected.took_candidate, result.took_candidate);
          mismatch_count++;
        end
        if (result.status !== oldest_expected.status) begin
          $display("%0t: status expected %b actual %b",
                   $time, oldest_expected.status, result.status);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL timestamp_later_than_top");
        $finish;
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    start          = 1'b0;
    item           = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_candidate_compare();
    test_fraction_step();
    test_calendar_rollover();
    test_bad_day();
    test_minute_overflow();
    test_random_traffic();

    repeat (RESULT_LATENCY + 5) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS timestamp_later_than_top");
    end else begin
      $display("FAIL timestamp_later_than_top");
    end
    $finish;
  end

endmodule
